// ----- hw/rtl/segmented_prime_sieve_counter_macros.svh -----
// ---------------------------------------------------------------------------
// Segmented prime sieve counter: assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ---------------------------------------------------------------------------
`ifndef SEGMENTED_PRIME_SIEVE_COUNTER_MACROS_SVH
`define SEGMENTED_PRIME_SIEVE_COUNTER_MACROS_SVH

// same-cycle implication
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sps_pkg.sv -----
// ---------------------------------------------------------------------------
// sps_pkg
// Shared constants and the sequencer state type of the prime sieve counter.
// ---------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int LEN_W       = 17;
  localparam int COUNT_W     = 17;
  localparam int SEG_MAX     = 65536;
  localparam int ADDR_W      = 16;              // bitmap address bits
  localparam int BASE_DEPTH  = 1 << ADDR_W;
  localparam int PADDR_W     = 2;
  localparam int PDATA_W     = 32;

  localparam logic [LEN_W-1:0]      LEN_RESET   = LEN_W'(SEG_MAX);
  localparam logic [VALUE_BITS:0]   VALUE_LIMIT = {1'b1, {VALUE_BITS{1'b0}}};
  localparam logic [ADDR_W-1:0]     ADDR_LAST   = {ADDR_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BFILL,
    ST_BP_SQ,
    ST_BP_CHK,
    ST_BMARK,
    ST_SFILL,
    ST_SP_SQ,
    ST_SP_CHK,
    ST_DIV,
    ST_DIVF,
    ST_SMARK,
    ST_CNT,
    ST_CNT_LAST,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/segmented_prime_sieve_counter.sv -----
// ---------------------------------------------------------------------------
// segmented_prime_sieve_counter
// Counts the primes in [segment_start, segment_start + segment_length) with
// a cached base-prime bitmap and a segment bitmap, both one bit per integer.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid / in_ready       | in_segment_start[31:0]
//  out     | output    | out_valid / out_ready     | out_prime_count[16:0], out_range_error
//  cfg     | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  The first in-range item of nonzero length after reset also sieves the base
//  bitmap (fill every entry, then strike the multiples); this is done once.
//  Per item: fill len segment bits, test each candidate p with p*p < end, take
//  start mod p (bit-serial remainder) for each base prime whose square is below
//  start, strike its multiples, then popcount. Range error or zero length: done.
//  Bitmap simple dual-port RAMs (one write, one read per cycle) set the pace.
//  in_ready is high only in idle; a finished result waits in the output
//  register while the next beat is taken. Sync active-low reset.
// ---------------------------------------------------------------------------
`default_nettype none

module segmented_prime_sieve_counter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sps_pkg::VALUE_BITS-1:0] in_segment_start,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sps_pkg::COUNT_W-1:0]        out_prime_count,
  output logic                               out_range_error,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sps_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [sps_pkg::PDATA_W-1:0]   pwdata,
  output logic [sps_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import sps_pkg::*;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]        len_cfg_r;
  logic [VALUE_BITS-1:0]   start_r, start_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [VALUE_BITS:0]     end_r, end_nxt;
  logic [2*LEN_W-1:0]      sq_r, sq_nxt;
  logic [LEN_W-1:0]        p_r, p_nxt;
  logic [LEN_W-1:0]        j_r, j_nxt;
  logic [LEN_W-1:0]        k_r, k_nxt;
  logic [LEN_W-1:0]        rem_r, rem_nxt;
  logic [4:0]              bit_r, bit_nxt;
  logic [COUNT_W-1:0]      cnt_r, cnt_nxt;
  logic                    err_r, err_nxt;
  logic                    base_done_r, base_done_nxt;
  logic                    rdv_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]      out_cnt_r;
  logic                    out_err_r;

  // bitmaps
  logic                    base_mem [BASE_DEPTH];
  logic                    seg_mem  [BASE_DEPTH];
  logic                    base_we, base_wdata, base_rd_r;
  logic [ADDR_W-1:0]       base_waddr, base_raddr;
  logic                    seg_we, seg_wdata, seg_rd_r;
  logic [ADDR_W-1:0]       seg_waddr, seg_raddr;

  // datapath helpers
  logic [LEN_W:0]          jn;
  logic                    jn_ge_len, jn_base_out;
  logic [2*LEN_W-1:0]      diff;
  logic [2*LEN_W-1:0]      p_sq;
  logic                    sq_ge_end, sq_ge_start, diff_lt_len, sq_base_out;
  logic [LEN_W:0]          rem_sh;
  logic                    rem_ge;
  logic [LEN_W-1:0]        rem_step;
  logic [LEN_W-1:0]        j_first;
  logic                    k_last_seg;
  logic                    accept_in, cfg_wr;
  logic [LEN_W-1:0]        len_sat;

  assign accept_in = in_valid && in_ready;
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = PDATA_W'(len_cfg_r);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_prime_count = out_cnt_r;
  assign out_range_error = out_err_r;

  assign len_sat     = (len_cfg_r > LEN_RESET) ? LEN_RESET : len_cfg_r;
  assign jn          = {1'b0, j_r} + {1'b0, p_r};
  assign jn_ge_len   = (jn >= {1'b0, len_r});
  assign jn_base_out = (jn > (LEN_W+1)'(ADDR_LAST));
  assign p_sq        = {{LEN_W{1'b0}}, p_r} * {{LEN_W{1'b0}}, p_r};
  assign sq_ge_end   = (sq_r >= (2*LEN_W)'(end_r));
  assign sq_ge_start = (sq_r >= (2*LEN_W)'(start_r));
  assign diff        = sq_r - (2*LEN_W)'(start_r);
  assign diff_lt_len = (diff < (2*LEN_W)'(len_r));
  assign sq_base_out = (sq_r > (2*LEN_W)'(ADDR_LAST));
  assign rem_sh      = {rem_r, start_r[bit_r]};
  assign rem_ge      = (rem_sh >= {1'b0, p_r});
  assign rem_step    = rem_ge ? LEN_W'(rem_sh - {1'b0, p_r}) : rem_sh[LEN_W-1:0];
  assign j_first     = (rem_r == '0) ? '0 : (p_r - rem_r);
  assign k_last_seg  = ((k_r + LEN_W'(1)) == len_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (end_r > VALUE_LIMIT || len_r == '0) state_nxt = ST_DONE;
        else if (!base_done_r)                  state_nxt = ST_BFILL;
        else                                    state_nxt = ST_SFILL;
      end
      ST_BFILL:    if (k_r[ADDR_W-1:0] == ADDR_LAST) state_nxt = ST_BP_SQ;
      ST_BP_SQ:    state_nxt = ST_BP_CHK;
      ST_BP_CHK: begin
        if (sq_base_out)    state_nxt = ST_SFILL;
        else if (base_rd_r) state_nxt = ST_BMARK;
        else                state_nxt = ST_BP_SQ;
      end
      ST_BMARK:    if (jn_base_out) state_nxt = ST_BP_SQ;
      ST_SFILL:    if (k_last_seg) state_nxt = ST_SP_SQ;
      ST_SP_SQ:    state_nxt = ST_SP_CHK;
      ST_SP_CHK: begin
        if (sq_ge_end)                   state_nxt = ST_CNT;
        else if (!base_rd_r)             state_nxt = ST_SP_SQ;
        else if (sq_ge_start)            state_nxt = diff_lt_len ? ST_SMARK : ST_SP_SQ;
        else                             state_nxt = ST_DIV;
      end
      ST_DIV:      if (bit_r == '0) state_nxt = ST_DIVF;
      ST_DIVF:     state_nxt = (j_first < len_r) ? ST_SMARK : ST_SP_SQ;
      ST_SMARK:    if (jn_ge_len) state_nxt = ST_SP_SQ;
      ST_CNT:      if (k_last_seg) state_nxt = ST_CNT_LAST;
      ST_CNT_LAST: state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    start_nxt     = start_r;
    len_nxt       = len_r;
    end_nxt       = end_r;
    sq_nxt        = sq_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    base_done_nxt = base_done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    base_we       = 1'b0;
    base_waddr    = k_r[ADDR_W-1:0];
    base_wdata    = 1'b0;
    base_raddr    = p_r[ADDR_W-1:0];
    seg_we        = 1'b0;
    seg_waddr     = k_r[ADDR_W-1:0];
    seg_wdata     = 1'b0;
    seg_raddr     = k_r[ADDR_W-1:0];
    if (rdv_r && seg_rd_r) cnt_nxt = cnt_r + COUNT_W'(1);
    case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          start_nxt = in_segment_start;
          len_nxt   = len_sat;
          end_nxt   = {1'b0, in_segment_start} + (VALUE_BITS+1)'(len_sat);
          cnt_nxt   = '0;
          err_nxt   = 1'b0;
        end
      end
      ST_CHECK: begin
        err_nxt = (end_r > VALUE_LIMIT);
        k_nxt   = '0;
        p_nxt   = LEN_W'(2);
      end
      ST_BFILL: begin
        base_we    = 1'b1;
        base_wdata = (k_r > LEN_W'(1));        // 0 and 1 are not prime
        k_nxt      = k_r + LEN_W'(1);
        if (k_r[ADDR_W-1:0] == ADDR_LAST) k_nxt = '0;
      end
      ST_BP_SQ:  sq_nxt = p_sq;
      ST_BP_CHK: begin
        if (sq_base_out) begin
          base_done_nxt = 1'b1;
          p_nxt         = LEN_W'(2);
        end else if (base_rd_r) begin
          j_nxt = sq_r[LEN_W-1:0];
        end else begin
          p_nxt = p_r + LEN_W'(1);
        end
      end
      ST_BMARK: begin
        base_we    = 1'b1;
        base_waddr = j_r[ADDR_W-1:0];
        j_nxt      = jn[LEN_W-1:0];
        if (jn_base_out) p_nxt = p_r + LEN_W'(1);
      end
      ST_SFILL: begin
        seg_we    = 1'b1;
        // integers 0 and 1 start out struck
        seg_wdata = !((start_r == '0 && k_r < LEN_W'(2)) ||
                      (start_r == VALUE_BITS'(1) && k_r == '0));
        k_nxt     = k_r + LEN_W'(1);
        if (k_last_seg) k_nxt = '0;
      end
      ST_SP_SQ:  sq_nxt = p_sq;
      ST_SP_CHK: begin
        if (sq_ge_end) begin
          k_nxt = '0;
        end else if (!base_rd_r) begin
          p_nxt = p_r + LEN_W'(1);
        end else if (sq_ge_start) begin
          j_nxt = diff[LEN_W-1:0];
          if (!diff_lt_len) p_nxt = p_r + LEN_W'(1);
        end else begin
          rem_nxt = '0;
          bit_nxt = 5'(VALUE_BITS - 1);
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;                  // start mod p, one bit a cycle
        bit_nxt = bit_r - 5'd1;
      end
      ST_DIVF: begin
        j_nxt = j_first;
        if (j_first >= len_r) p_nxt = p_r + LEN_W'(1);
      end
      ST_SMARK: begin
        seg_we    = 1'b1;
        seg_waddr = j_r[ADDR_W-1:0];
        j_nxt     = jn[LEN_W-1:0];
        if (jn_ge_len) p_nxt = p_r + LEN_W'(1);
      end
      ST_CNT:    k_nxt = k_r + LEN_W'(1);
      ST_DONE: begin
        if (!out_valid_r || out_ready) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_cfg_r   <= LEN_RESET;
      base_done_r <= 1'b0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_done_r <= base_done_nxt;
      out_valid_r <= out_valid_nxt;
      rdv_r       <= (state_r == ST_CNT);
      if (cfg_wr) len_cfg_r <= pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
    end_r   <= end_nxt;
    sq_r    <= sq_nxt;
    p_r     <= p_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    cnt_r   <= cnt_nxt;
    err_r   <= err_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_cnt_r <= err_r ? '0 : cnt_r;
      out_err_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_waddr] <= base_wdata;
    base_rd_r <= base_mem[base_raddr];
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
    seg_rd_r <= seg_mem[seg_raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sps_checker.sv -----
// ---------------------------------------------------------------------------
// sps_checker
// Port-level checks on the prime sieve counter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "segmented_prime_sieve_counter_macros.svh"

module sps_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [sps_pkg::COUNT_W-1:0]    out_prime_count,
  input wire logic                           out_range_error
);
  import sps_pkg::*;

  `SPS_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready after accepted beat")
  `SPS_ASSERT_NOW(a_err_zero, out_valid && out_range_error, out_prime_count == '0, "range error with count")
  `SPS_ASSERT_NOW(a_count_max, out_valid, out_prime_count <= COUNT_W'(SEG_MAX), "count above segment size")
  `SPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_prime_count), "stalled result changed")

endmodule

bind segmented_prime_sieve_counter sps_checker u_sps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_prime_count (out_prime_count),
  .out_range_error (out_range_error)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: segmented prime sieve counter testbench
// Walks a table of directed segments and length settings, then runs random
// segments under several lengths. Typed rows carry their expected counts, a
// local sieve predicts the rest, and results are compared in order against
// the queue of predicted counts.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_SEG_LEN = '0;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int BASE_TOP = 65537;

  typedef enum logic {ROW_CFG, ROW_SEG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [31:0]        value;
    bit                 typed;
    logic [COUNT_W-1:0] count;
    logic               range_err;
  } plan_row_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               range_err;
  } seg_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_segment_start = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COUNT_W-1:0]    out_prime_count;
  logic                  out_range_error;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  segmented_prime_sieve_counter DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_segment_start,
    .out_valid, .out_ready, .out_prime_count, .out_range_error,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #6 clk = ~clk;
  end

  longint      cycles = 0;
  int          errors = 0;
  bit          composite [0:BASE_TOP];
  bit          seg_live [0:SEG_MAX-1];
  logic [LEN_W-1:0] seg_len = LEN_RESET;
  seg_result_t pending_counts [$];
  plan_row_t   plan [18];
  int          burst_left = 0;
  int          big_budget = 3;

  function automatic seg_result_t count_primes(input logic [31:0] start);
    seg_result_t r;
    longint s, len, e, first, p, j;
    int n;
    s = start;
    len = (seg_len > SEG_MAX) ? SEG_MAX : seg_len;
    e = s + len;
    r.count = '0;
    r.range_err = 1'b0;
    if (e > (64'd1 << VALUE_BITS)) begin
      r.range_err = 1'b1;
      return r;
    end
    for (j = 0; j < len; j++) seg_live[j] = 1'b1;
    for (p = 2; p * p < e; p++) begin
      if (composite[p]) continue;
      first = ((s + p - 1) / p) * p;
      if (first < p * p) first = p * p;
      for (j = first - s; j < len; j += p) seg_live[j] = 1'b0;
    end
    n = 0;
    for (j = 0; j < len; j++)
      if (seg_live[j] && (s + j) >= 2) n++;
    r.count = COUNT_W'(n);
    return r;
  endfunction

  // cycle counter, timeout and the receiver's stall pattern
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles[12]) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= (((cycles[3:0] * 7) ^ cycles[9:4]) % 4) != 0;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    seg_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_counts.size() == 0) begin
        $error("result beat with nothing pending: count %0d", out_prime_count);
        errors++;
      end else begin
        exp_r = pending_counts.pop_front();
        if (out_prime_count !== exp_r.count) begin
          $error("prime_count: expected %0d, actual %0d", exp_r.count, out_prime_count);
          errors++;
        end
        if (out_range_error !== exp_r.range_err) begin
          $error("range_error: expected %0d, actual %0d",
                 exp_r.range_err, out_range_error);
          errors++;
        end
      end
    end
  end

  task automatic write_seg_len(input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SEG_LEN;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    seg_len = v[LEN_W-1:0];
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_segment(input logic [31:0] start, input bit typed,
                              input seg_result_t typed_r);
    seg_result_t r;
    if (burst_left == 0) begin
      int gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_segment_start <= start;
    do @(posedge clk); while (!in_ready);
    r = typed ? typed_r : count_primes(start);
    pending_counts = {pending_counts, r};
  endtask

  function automatic logic [31:0] random_start();
    int pick = $urandom_range(0, 99);
    logic [31:0] s;
    if (pick < 10) return $urandom_range(0, 300);
    if (pick < 24 && seg_len >= 2) begin
      s = 32'hFFFF_FFFF - $urandom_range(0, seg_len - 2);  // runs past the top
      return s;
    end
    if (pick < 28 && big_budget > 0) begin
      big_budget--;
      s = $urandom;
      if (64'(s) + seg_len > (64'd1 << VALUE_BITS)) s = s - seg_len;
      return s;
    end
    return $urandom_range(0, 1 << 20);
  endfunction

  initial begin
    seg_result_t none;
    logic [31:0] lens [4];
    longint p, j;
    none = '{count: '0, range_err: 1'b0};
    for (p = 2; p * p <= BASE_TOP; p++)
      if (!composite[p])
        for (j = p * p; j <= BASE_TOP; j += p) composite[j] = 1'b1;

    plan[0]  = '{ROW_SEG, 32'd0,          1, 17'd6542, 1'b0};
    plan[1]  = '{ROW_SEG, 32'hFFFF_0001,  1, 17'd0,    1'b1};
    plan[2]  = '{ROW_SEG, 32'hFFFF_0000,  0, 17'd0,    1'b0};
    plan[3]  = '{ROW_CFG, 32'd0,          0, 17'd0,    1'b0};  // empty segment
    plan[4]  = '{ROW_SEG, 32'd0,          1, 17'd0,    1'b0};
    plan[5]  = '{ROW_SEG, 32'hFFFF_FFFF,  1, 17'd0,    1'b0};
    plan[6]  = '{ROW_CFG, 32'd1,          0, 17'd0,    1'b0};
    plan[7]  = '{ROW_SEG, 32'd0,          1, 17'd0,    1'b0};
    plan[8]  = '{ROW_SEG, 32'd1,          1, 17'd0,    1'b0};
    plan[9]  = '{ROW_SEG, 32'd2,          1, 17'd1,    1'b0};
    plan[10] = '{ROW_SEG, 32'hFFFF_FFFF,  1, 17'd0,    1'b0};  // ends exactly at the top
    plan[11] = '{ROW_CFG, 32'd131071,     0, 17'd0,    1'b0};  // saturates to max length
    plan[12] = '{ROW_SEG, 32'hFFFF_0001,  1, 17'd0,    1'b1};
    plan[13] = '{ROW_SEG, 32'd1,          1, 17'd6542, 1'b0};
    plan[14] = '{ROW_CFG, 32'd64,         0, 17'd0,    1'b0};
    plan[15] = '{ROW_SEG, 32'd0,          1, 17'd18,   1'b0};
    plan[16] = '{ROW_SEG, 32'hFFFF_FFC1,  1, 17'd0,    1'b1};
    plan[17] = '{ROW_SEG, 32'd100,        0, 17'd0,    1'b0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_seg_len(plan[i].value);
      end else begin
        send_segment(plan[i].value, plan[i].typed,
                     '{count: plan[i].count, range_err: plan[i].range_err});
      end
    end

    lens[0] = $urandom_range(2, 300);
    lens[1] = 63;
    lens[2] = $urandom_range(65, 1000);
    lens[3] = $urandom_range(2, 40);
    foreach (lens[k]) begin
      drain();
      write_seg_len(lens[k]);
      repeat (25) send_segment(random_start(), 1'b0, none);
    end

    drain();
    while (pending_counts.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
